// ===== hw/rtl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel select package
// Shared widths, action and status codes, and the command word that the
// front end hands to the selection engine.
// ----------------------------------------------------------------------------
package rws_pkg;

   localparam int DEFAULT_MAX_POPULATION = 256;

   localparam int FIT_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int START_W     = 8;
   localparam int INDEX_W     = 8;
   localparam int STATUS_W    = 2;
   localparam int ACTION_W    = 2;
   localparam int TOTAL_W     = 24;
   localparam int TARGET_W    = FRAC_W + TOTAL_W;
   localparam int THRESH_W    = TARGET_W - 16 + 1;
   localparam int REQ_TDATA_W = FIT_W + FRAC_W + START_W;
   localparam int RSP_TDATA_W = 16;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SELECT = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;

   typedef struct packed {
      action_type         kind;
      logic [FIT_W-1:0]   fitness;
      logic [FRAC_W-1:0]  fraction;
      logic [START_W-1:0] start;
   } cmd_type;

endpackage

// ===== hw/rtl/rws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rws_front.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel select front end
// Accepts request words, drops unknown actions and queues the rest in a
// two-entry command queue for the engine.
// ----------------------------------------------------------------------------
module rws_front
   import rws_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]    req_tuser,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  logic                   cmd_pop
);

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int FILL_W = $clog2(QDEPTH + 1);

   cmd_type            queue_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               legal;
   logic               push;
   cmd_type            decoded;

   // Action code 3 means nothing; such a word is taken and discarded.
   assign legal = (req_tuser == ACT_LOAD) || (req_tuser == ACT_SELECT) ||
                  (req_tuser == ACT_CLEAR);

   assign decoded.kind     = action_type'(req_tuser);
   assign decoded.fitness  = req_tdata[FIT_W-1:0];
   assign decoded.fraction = req_tdata[FIT_W+FRAC_W-1:FIT_W];
   assign decoded.start    = req_tdata[REQ_TDATA_W-1:FIT_W+FRAC_W];

   assign req_tready = (fill_ff != FILL_W'(QDEPTH));
   assign push       = req_tvalid && req_tready && legal;
   assign cmd_valid  = (fill_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== hw/rtl/rws_engine.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel select engine
// Executes queued load, clear and select commands; a select reduces the
// start index modulo the population, then walks the fitness store.
// ----------------------------------------------------------------------------
module rws_engine
   import rws_pkg::*;
#(
   parameter int MAX_POPULATION = DEFAULT_MAX_POPULATION
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  cmd_type                          cmd,
   output logic                             cmd_pop,
   output logic                             ram_wr_en,
   output logic [$clog2(MAX_POPULATION)-1:0] ram_wr_addr,
   output logic [FIT_W-1:0]                 ram_wr_data,
   output logic                             ram_rd_en,
   output logic [$clog2(MAX_POPULATION)-1:0] ram_rd_addr,
   input  logic [FIT_W-1:0]                 ram_rd_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [INDEX_W-1:0]               out_index,
   output logic [STATUS_W-1:0]              out_status
);

   localparam int AW  = $clog2(MAX_POPULATION);
   localparam int CW  = $clog2(MAX_POPULATION + 1);
   localparam int SW  = FIT_W + CW;
   localparam int TW  = (SW > THRESH_W) ? SW : THRESH_W;
   localparam int BW  = $clog2(START_W);
   localparam logic [CW-1:0] POP_MAX = CW'(MAX_POPULATION);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOD,
      S_WALK
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [AW-1:0]       rd_pos_ff, rd_pos_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [CW-1:0]       seen_ff, seen_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic                out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic                out_free;
   logic [TOTAL_W:0]    total_sum;
   logic [CW:0]         rem_shift;
   logic [CW-1:0]       pos_inc;
   logic [SW-1:0]       sum_next;
   logic [CW-1:0]       seen_next;
   logic                crossed;

   assign out_free  = !out_valid_ff || out_ready;
   assign total_sum = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(cmd.fitness);
   assign rem_shift = {rem_ff, start_ff[bit_ff]};
   assign pos_inc   = CW'(pos_ff) + CW'(1);
   assign sum_next  = sum_ff + SW'(ram_rd_data);
   assign seen_next = seen_ff + CW'(1);
   assign crossed   = (TW'(sum_next) >= TW'(thresh_ff)) || (seen_next == count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      target_in     = target_ff;
      thresh_in     = thresh_ff;
      start_in      = start_ff;
      bit_in        = bit_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      rd_pos_in     = rd_pos_ff;
      rd_vld_in     = rd_vld_ff;
      seen_in       = seen_ff;
      sum_in        = sum_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_index_in  = out_index_ff;
      out_status_in = out_status_ff;
      cmd_pop       = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[AW-1:0];
      ram_wr_data   = cmd.fitness;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  ACT_LOAD: begin
                     cmd_pop = 1'b1;
                     // A load into a full population is dropped.
                     if (count_ff < POP_MAX) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                        total_in  = total_sum[TOTAL_W] ? TOTAL_MAX
                                                       : total_sum[TOTAL_W-1:0];
                     end
                  end
                  ACT_CLEAR: begin
                     cmd_pop  = 1'b1;
                     count_in = '0;
                     total_in = '0;
                  end
                  ACT_SELECT: begin
                     // Taken only when the result register will be free, so
                     // the walk can always deliver its result.
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        if (count_ff == '0) begin
                           out_valid_in  = 1'b1;
                           out_index_in  = cmd.start;
                           out_status_in = STATUS_EMPTY;
                        end else if (total_ff == '0) begin
                           out_valid_in  = 1'b1;
                           out_index_in  = cmd.start;
                           out_status_in = STATUS_ZERO;
                        end else begin
                           target_in = TARGET_W'(cmd.fraction) * TARGET_W'(total_ff);
                           start_in  = cmd.start;
                           bit_in    = BW'(START_W - 1);
                           rem_in    = '0;
                           state_in  = S_MOD;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end

         S_MOD: begin
            // Restoring remainder, one start bit per cycle, MSB first.
            if (rem_shift >= {1'b0, count_ff}) begin
               rem_in = CW'(rem_shift - {1'b0, count_ff});
            end else begin
               rem_in = rem_shift[CW-1:0];
            end
            // sum*65536 >= target  is the same as  sum >= ceil(target/65536).
            thresh_in = THRESH_W'(target_ff[TARGET_W-1:16]) +
                        THRESH_W'(|target_ff[15:0]);
            bit_in = bit_ff - BW'(1);
            if (bit_ff == '0) begin
               pos_in    = rem_in[AW-1:0];
               rd_vld_in = 1'b0;
               seen_in   = '0;
               sum_in    = '0;
               state_in  = S_WALK;
            end
         end

         S_WALK: begin
            // Reads are issued one ahead of the accumulate.
            ram_rd_en = 1'b1;
            pos_in    = (pos_inc == count_ff) ? '0 : pos_ff + AW'(1);
            rd_pos_in = pos_ff;
            rd_vld_in = 1'b1;
            if (rd_vld_ff) begin
               sum_in  = sum_next;
               seen_in = seen_next;
               if (crossed) begin
                  out_valid_in  = 1'b1;
                  out_index_in  = INDEX_W'(rd_pos_ff);
                  out_status_in = STATUS_OK;
                  state_in      = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
      end
      target_ff     <= target_in;
      thresh_ff     <= thresh_in;
      start_ff      <= start_in;
      bit_ff        <= bit_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      rd_pos_ff     <= rd_pos_in;
      seen_ff       <= seen_in;
      sum_ff        <= sum_in;
      out_index_ff  <= out_index_in;
      out_status_ff <= out_status_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_index  = out_index_ff;
   assign out_status = out_status_ff;

endmodule

// ===== hw/rtl/roulette_wheel_select_unit.sv =====
// For a word taken while the queue is empty and the engine is idle: a load or clear takes effect
// and gives no result; a select on an empty population or zero total raises rsp_tvalid without a
// walk, otherwise after a modulo step per start bit and a walk over k <= population count (at
// most MAX_POPULATION) fitnesses, one a cycle. Throughput: one load, clear or trivial select per
// cycle, a select only while the result register is free; a walking select holds the engine until
// its walk ends. Synchronous reset empties queue, population, total; the store is not cleared.
// ----------------------------------------------------------------------------
// Roulette wheel select unit
// Fitness-proportionate selection over a stored population with a running
// fitness total, driven by load, select and clear words.
// ----------------------------------------------------------------------------
module roulette_wheel_select_unit
   import rws_pkg::*;
#(
   parameter int MAX_POPULATION = DEFAULT_MAX_POPULATION
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] fitness_value, [31:16] random_fraction, [39:32] start_index
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] action: 0 load, 1 select, 2 clear
   input  logic [ACTION_W-1:0]    req_tuser,
   // Result channel, one word per select.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] selected_index, [9:8] status, [15:10] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW  = $clog2(MAX_POPULATION);
   localparam int PAD = RSP_TDATA_W - INDEX_W - STATUS_W;

   cmd_type             cmd;
   logic                cmd_valid;
   logic                cmd_pop;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [FIT_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [FIT_W-1:0]    ram_rd_data;
   logic [INDEX_W-1:0]  out_index;
   logic [STATUS_W-1:0] out_status;

   // The front end decodes each word and drops unknown actions, so the
   // engine only ever sees load, select and clear commands in order.
   rws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // The engine owns the population count, the saturating total and the
   // result register; loads and clears go on while a result word waits
   // downstream, and a select is taken only once that register is free.
   rws_engine #(
      .MAX_POPULATION (MAX_POPULATION)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_index   (out_index),
      .out_status  (out_status)
   );

   // Fitness store: only entries below the population count are read, and
   // each of those has been written by a load.
   rws_ram #(
      .WIDTH (FIT_W),
      .DEPTH (MAX_POPULATION)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata = {{PAD{1'b0}}, out_status, out_index};

endmodule

// ===== hw/rtl/rws_checker.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel select checker
// Port-level assertions on the result channel and reset behavior.
// ----------------------------------------------------------------------------
module rws_checker
   import rws_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [ACTION_W-1:0]    req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A result word that is not taken stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Only the three defined status codes are produced, with zero padding.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[9:8] == STATUS_OK) || (rsp_tdata[9:8] == STATUS_EMPTY) ||
                      (rsp_tdata[9:8] == STATUS_ZERO)) && (rsp_tdata[15:10] == '0))
      else $error("bad status or padding on result word");

   // Right after reset no result is pending and the command queue is open.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

endmodule

bind roulette_wheel_select_unit rws_checker u_rws_checker (.*);

// ===== dv/rws_select_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel select checker
// Watches the request and result channels of the select unit. It keeps its
// own population and running total, predicts the pick for every accepted
// select word, and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module rws_select_checker
   import rws_pkg::*;
#(
   parameter int MAX_POPULATION = DEFAULT_MAX_POPULATION
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]    req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     fail_count,
   output int                     pending_results
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [INDEX_W-1:0]  index;
      logic [STATUS_W-1:0] status;
   } pick_type;

   logic [FIT_W-1:0]   fitness_mem [MAX_POPULATION];
   int                 members;
   logic [TOTAL_W-1:0] fitness_sum;
   pick_type           expected_picks [$];
   int                 picks_seen;

   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", what);
      end
   endtask

   // Applies one accepted word to the shadow population and queues the pick
   // that a select word must return.
   function automatic void apply_word(input logic [ACTION_W-1:0] act,
                                      input logic [FIT_W-1:0]    fit,
                                      input logic [FRAC_W-1:0]   frac,
                                      input logic [START_W-1:0]  start);
      logic [TOTAL_W:0] grown;
      logic [63:0]      target;
      logic [63:0]      running;
      int               pos;
      int               pick;
      int               steps;
      logic             crossed;
      pick_type         chosen;
      case (act)
         ACT_LOAD: begin
            // A load into a full population is dropped.
            if (members < MAX_POPULATION) begin
               fitness_mem[members] = fit;
               members++;
               grown       = fitness_sum + fit;
               fitness_sum = (grown > TOTAL_MAX) ? TOTAL_MAX : grown[TOTAL_W-1:0];
            end
         end
         ACT_CLEAR: begin
            members     = 0;
            fitness_sum = '0;
         end
         ACT_SELECT: begin
            chosen.index  = start;
            chosen.status = STATUS_OK;
            if (members == 0) begin
               chosen.status = STATUS_EMPTY;
            end else if (fitness_sum == '0) begin
               chosen.status = STATUS_ZERO;
            end else begin
               // Walk cyclically from the start until sum * 2^16 reaches
               // fraction * total; without a crossing the last visited wins.
               target  = 64'(frac) * 64'(fitness_sum);
               running = '0;
               pos     = int'(start) % members;
               pick    = pos;
               crossed = 1'b0;
               for (steps = 0; steps < members && !crossed; steps++) begin
                  pick    = pos;
                  running = running + 64'(fitness_mem[pos]);
                  crossed = ((running << 16) >= target);
                  pos     = (pos + 1 == members) ? 0 : pos + 1;
               end
               chosen.index = pick[INDEX_W-1:0];
            end
            expected_picks.push_back(chosen);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      pick_type            want;
      logic [INDEX_W-1:0]  got_index;
      logic [STATUS_W-1:0] got_status;
      if (reset) begin
         members     = 0;
         fitness_sum = '0;
         picks_seen  = 0;
         fail_count  = 0;
         expected_picks.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_word(req_tuser,
                       req_tdata[FIT_W-1:0],
                       req_tdata[FIT_W+FRAC_W-1:FIT_W],
                       req_tdata[REQ_TDATA_W-1:FIT_W+FRAC_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_index  = rsp_tdata[INDEX_W-1:0];
            got_status = rsp_tdata[INDEX_W+STATUS_W-1:INDEX_W];
            if (expected_picks.size() == 0) begin
               flag_failure($sformatf("unexpected result word: index %0d status %0d",
                                      got_index, got_status));
            end else begin
               want = expected_picks.pop_front();
               if (got_index !== want.index || got_status !== want.status) begin
                  flag_failure($sformatf(
                     "select %0d: expected index %0d status %0d, got index %0d status %0d",
                     picks_seen, want.index, want.status, got_index, got_status));
               end
            end
            picks_seen++;
         end
      end
      pending_results = expected_picks.size();
   end

endmodule

// ===== dv/tb_roulette_wheel_select_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel select unit testbench
// Drives load, select, clear and unused words into the unit, first a short
// directed sequence and then random populations of mixed sizes, under four
// idle and stall patterns. A checker beside the unit predicts every pick.
// ----------------------------------------------------------------------------
module tb_roulette_wheel_select_unit;
   import rws_pkg::*;

   localparam int MAX_POPULATION = DEFAULT_MAX_POPULATION;

   // The one action code that the package leaves unnamed; the unit ignores it.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int ITEM_TARGET  = 1900;
   localparam int PHASES       = 4;
   localparam int HOLD_CYCLES  = 600;
   // A select on a full population may walk all 256 fitnesses.
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 3_000_000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [15:0] fitness_value, [31:16] random_fraction, [39:32] start_index
   logic [REQ_TDATA_W-1:0] req_tdata;
   // [1:0] action
   logic [ACTION_W-1:0]    req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [7:0] selected_index, [9:8] status, [15:10] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending_results;

   // Idle and stall chances in percent, set per phase by the stimulus.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   // Bumped by the stimulus to ask the receiver for one long hold-off.
   int hold_requests      = 0;
   // Population size as the stimulus sees it, used only to shape sequences.
   int shadow_members     = 0;
   // Accepted words that the unit acts on (unused actions and loads into a
   // full population do not count).
   int words_counted      = 0;
   int cycle_count        = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   roulette_wheel_select_unit #(
      .MAX_POPULATION(MAX_POPULATION)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   rws_select_checker #(
      .MAX_POPULATION(MAX_POPULATION)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .fail_count     (fail_count),
      .pending_results(pending_results)
   );

   // Watchdog: a run that hangs on a handshake ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[roulette_wheel_select_unit] ERROR");
         $finish;
      end
   end

   // Result side. Ready changes only at falling edges. A hold-off request
   // keeps ready low for a long stretch, counted here, so that the unit's
   // command queue fills and it stops taking request words.
   initial begin : receiver
      int holds_seen;
      holds_seen = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Fitness values lean toward the edges: zero, all ones and small values
   // show up often next to fully random ones.
   function automatic logic [FIT_W-1:0] draw_fitness();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return FIT_W'($urandom_range(15));
         default: return FIT_W'($urandom());
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] draw_fraction();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return FRAC_W'(16'h8000);
         default: return FRAC_W'($urandom());
      endcase
   endfunction

   // Offers one word and returns at the falling edge after it was taken.
   // The caller either offers the next word or lowers valid at that edge, so
   // a taken word is never presented twice.
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [FIT_W-1:0]    fit,
                            input logic [FRAC_W-1:0]   frac,
                            input logic [START_W-1:0]  start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {start, frac, fit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (act == ACT_CLEAR) begin
         shadow_members = 0;
         words_counted++;
      end else if (act == ACT_SELECT) begin
         words_counted++;
      end else if (act == ACT_LOAD && shadow_members < MAX_POPULATION) begin
         shadow_members++;
         words_counted++;
      end
   endtask

   // Lowers valid and waits until every predicted result word has arrived.
   // Valid is lowered before the wait, so the next word is offered at a
   // later falling edge.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
   endtask

   // One population: usually a clear, a run of loads and a few selects with
   // random content. Now and then the clear is skipped so that populations
   // pile up, a stray unused word is mixed in, or every fitness is zero.
   // A few populations fill the store and go past its end.
   task automatic run_episode();
      int  size_roll;
      int  loads;
      int  selects;
      bit  all_zero;
      if ($urandom_range(9) != 0) begin
         send_word(ACT_CLEAR, FIT_W'($urandom()), FRAC_W'($urandom()),
                   START_W'($urandom()));
      end
      size_roll = $urandom_range(99);
      if (size_roll < 3) begin
         loads = $urandom_range(MAX_POPULATION - 6, MAX_POPULATION + 2);
      end else if (size_roll < 12) begin
         loads = $urandom_range(13, 64);
      end else begin
         loads = $urandom_range(0, 12);
      end
      all_zero = ($urandom_range(11) == 0);
      repeat (loads) begin
         if ($urandom_range(24) == 0) begin
            send_word(ACT_UNUSED, FIT_W'($urandom()), FRAC_W'($urandom()),
                      START_W'($urandom()));
         end
         send_word(ACT_LOAD, all_zero ? FIT_W'(0) : draw_fitness(),
                   FRAC_W'($urandom()), START_W'($urandom()));
      end
      // Large populations make every select slow, so they get fewer.
      selects = (loads > 64) ? $urandom_range(1, 3) : $urandom_range(1, 6);
      repeat (selects) begin
         send_word(ACT_SELECT, FIT_W'($urandom()), draw_fraction(),
                   START_W'($urandom()));
      end
   endtask

   initial begin : stimulus
      int phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = ACT_LOAD;
      req_tdata  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // A select on an empty population returns its start index with the
      // empty status, and an unused action changes nothing.
      send_word(ACT_SELECT, '0, 16'h1234, 8'hFF);
      send_word(ACT_UNUSED, '1, '1, '1);
      send_word(ACT_SELECT, '1, '0, 8'h00);

      // Two zero fitnesses: the total is zero, so the start index comes back
      // with the zero-total status.
      send_word(ACT_LOAD, '0, '1, '1);
      send_word(ACT_LOAD, '0, '0, '0);
      send_word(ACT_SELECT, '1, 16'h8000, 8'hAA);

      // Clear, then a small population with extreme fitnesses, including a
      // zero entry in the middle of the walk.
      send_word(ACT_CLEAR, '1, '1, '1);
      send_word(ACT_LOAD, 16'hFFFF, '0, '0);
      send_word(ACT_LOAD, 16'h0001, '1, '1);
      send_word(ACT_LOAD, 16'h0000, '0, '0);
      send_word(ACT_LOAD, 16'h00FF, '1, '1);
      // A zero fraction crosses at the first entry visited.
      send_word(ACT_SELECT, '0, '0, 8'h00);
      // 255 modulo 4 starts at the last individual and wraps around.
      send_word(ACT_SELECT, '1, '1, 8'hFF);
      send_word(ACT_SELECT, '0, 16'h8000, 8'h02);
      send_word(ACT_SELECT, '1, '1, 8'h01);
      send_word(ACT_SELECT, '0, 16'h0001, 8'h03);
      send_word(ACT_UNUSED, '0, '0, '0);
      send_word(ACT_SELECT, '1, 16'hC000, 8'h80);

      // After a clear the population is empty again.
      send_word(ACT_CLEAR, '0, '0, '0);
      send_word(ACT_SELECT, '0, 16'h5555, 8'h5A);
      wait_for_results();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 74;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 74;
            end
            default: begin
               sender_idle_pct    = 29;
               receiver_stall_pct = 29;
            end
         endcase

         if (phase == 0) begin
            // Back-to-back selects against a receiver that holds off for a
            // long time: the engine and its queue fill and the request side
            // has to stall.
            send_word(ACT_CLEAR, '0, '0, '0);
            repeat (6) begin
               send_word(ACT_LOAD, draw_fitness(), FRAC_W'($urandom()),
                         START_W'($urandom()));
            end
            hold_requests++;
            repeat (16) begin
               send_word(ACT_SELECT, FIT_W'($urandom()), draw_fraction(),
                         START_W'($urandom()));
            end
         end

         while (words_counted < (phase + 1) * ITEM_TARGET / PHASES) begin
            run_episode();
         end
         // The sender pauses here until every pick has come back.
         wait_for_results();
      end

      // Give a late or extra result word time to show up.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[roulette_wheel_select_unit] OK");
      end else begin
         $display("[roulette_wheel_select_unit] ERROR");
      end
      $finish;
   end

endmodule
